// File: sv/vpm_pkg.sv
// Package for the value to pseudocolour mapper: mode and register codes,
// pixel and flag types, and the small colour tables. Depends on nothing.
package vpm_pkg;

   localparam int MODE_WIDTH = 3;
   localparam int REG_INDEX_WIDTH = 2;
   localparam int QUOT_WIDTH = 8;
   localparam int PCT_WIDTH = 7;
   localparam int CHAN_WIDTH = 8;
   localparam int BAND_WIDTH = 4;
   localparam int PCT_FULL = 100;
   localparam int GRAY_FULL = 255;

   localparam logic [REG_INDEX_WIDTH-1:0] REG_MAP_MODE   = 2'd0;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_RANGE_LOW  = 2'd1;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_RANGE_HIGH = 2'd2;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_RAINBOW_LINEAR = 3'd0,
      MODE_RAINBOW_STEP   = 3'd1,
      MODE_GRAY_LINEAR    = 3'd2,
      MODE_GRAY_STEP      = 3'd3,
      MODE_BLACK_WHITE    = 3'd4
   } map_mode_type;

   typedef struct packed {
      logic [CHAN_WIDTH-1:0] red;
      logic [CHAN_WIDTH-1:0] green;
      logic [CHAN_WIDTH-1:0] blue;
   } rgb_type;

   typedef struct packed {
      logic below;
      logic above;
      logic bright;
   } flag_type;

   localparam rgb_type RGB_BLACK = '{red: 8'd0, green: 8'd0, blue: 8'd0};
   localparam rgb_type RGB_WHITE = '{red: 8'd255, green: 8'd255, blue: 8'd255};

   // Exact x/10 for x below 128, by the reciprocal 205/2048.
   function automatic logic [BAND_WIDTH-1:0] div_ten(input logic [PCT_WIDTH-1:0] x);
      logic [14:0] prod;
      prod = 15'(x) * 15'(205);
      return prod[14:11];
   endfunction

   function automatic logic [BAND_WIDTH-1:0] band_of(input logic [PCT_WIDTH-1:0] p);
      logic [BAND_WIDTH-1:0] b;
      b = div_ten(p);
      return (b > 4'd9) ? 4'd9 : b;
   endfunction

   function automatic logic [CHAN_WIDTH-1:0] ramp_half(input logic [BAND_WIDTH-1:0] d);
      logic [CHAN_WIDTH-1:0] v;
      case (d)
         4'd0: v = 8'd0;
         4'd1: v = 8'd12;
         4'd2: v = 8'd25;
         4'd3: v = 8'd38;
         4'd4: v = 8'd50;
         4'd5: v = 8'd63;
         4'd6: v = 8'd76;
         4'd7: v = 8'd88;
         4'd8: v = 8'd101;
         4'd9: v = 8'd114;
         default: v = 8'd0;
      endcase
      return v;
   endfunction

   function automatic logic [CHAN_WIDTH-1:0] ramp_full(input logic [BAND_WIDTH-1:0] d);
      logic [CHAN_WIDTH-1:0] v;
      case (d)
         4'd0: v = 8'd0;
         4'd1: v = 8'd25;
         4'd2: v = 8'd51;
         4'd3: v = 8'd76;
         4'd4: v = 8'd102;
         4'd5: v = 8'd127;
         4'd6: v = 8'd153;
         4'd7: v = 8'd178;
         4'd8: v = 8'd204;
         4'd9: v = 8'd229;
         default: v = 8'd0;
      endcase
      return v;
   endfunction

   function automatic rgb_type rainbow_linear(input logic [PCT_WIDTH-1:0] p);
      logic [PCT_WIDTH-1:0] n;
      logic [BAND_WIDTH-1:0] band;
      logic [BAND_WIDTH-1:0] d;
      logic [CHAN_WIDTH-1:0] a;
      logic [CHAN_WIDTH-1:0] b;
      rgb_type c;
      n = p - 7'd5;
      band = div_ten(n);
      d = BAND_WIDTH'(n - (7'({band, 3'b000}) + 7'({band, 1'b0})));
      a = ramp_half(d);
      b = ramp_full(d);
      if (p < 7'd5) begin
         c = '{red: 8'd255, green: 8'd0, blue: 8'd255};
      end else begin
         case (band)
            4'd0: c = '{red: 8'd255 - a, green: 8'd0, blue: 8'd255};
            4'd1: c = '{red: 8'd127 - a, green: 8'd0, blue: 8'd255};
            4'd2: c = '{red: 8'd0, green: a, blue: 8'd255};
            4'd3: c = '{red: 8'd0, green: 8'd127 + a, blue: 8'd255};
            4'd4: c = '{red: 8'd0, green: 8'd255, blue: 8'd255 - a};
            4'd5: c = '{red: 8'd0, green: 8'd255, blue: 8'd127 - a};
            4'd6: c = '{red: b, green: 8'd255, blue: 8'd0};
            4'd7: c = '{red: 8'd255, green: 8'd255 - (b >> 1), blue: 8'd0};
            4'd8: c = '{red: 8'd255, green: 8'd127 - a, blue: 8'd0};
            default: c = '{red: 8'd255, green: 8'd0, blue: 8'd0};
         endcase
      end
      return c;
   endfunction

   function automatic rgb_type rainbow_step(input logic [BAND_WIDTH-1:0] band);
      rgb_type c;
      case (band)
         4'd0: c = '{red: 8'd255, green: 8'd0, blue: 8'd255};
         4'd1: c = '{red: 8'd127, green: 8'd0, blue: 8'd255};
         4'd2: c = '{red: 8'd0, green: 8'd0, blue: 8'd255};
         4'd3: c = '{red: 8'd0, green: 8'd127, blue: 8'd255};
         4'd4: c = '{red: 8'd0, green: 8'd255, blue: 8'd255};
         4'd5: c = '{red: 8'd0, green: 8'd255, blue: 8'd127};
         4'd6: c = '{red: 8'd0, green: 8'd255, blue: 8'd0};
         4'd7: c = '{red: 8'd255, green: 8'd255, blue: 8'd0};
         4'd8: c = '{red: 8'd255, green: 8'd127, blue: 8'd0};
         default: c = '{red: 8'd255, green: 8'd0, blue: 8'd0};
      endcase
      return c;
   endfunction

   function automatic logic [CHAN_WIDTH-1:0] gray_step(input logic [BAND_WIDTH-1:0] band);
      logic [CHAN_WIDTH-1:0] v;
      case (band)
         4'd0: v = 8'd255;
         4'd1: v = 8'd227;
         4'd2: v = 8'd199;
         4'd3: v = 8'd170;
         4'd4: v = 8'd142;
         4'd5: v = 8'd114;
         4'd6: v = 8'd85;
         4'd7: v = 8'd57;
         4'd8: v = 8'd29;
         default: v = 8'd0;
      endcase
      return v;
   endfunction

endpackage

// File: sv/vpm_if.sv
// Channel interfaces of the pseudocolour mapper: sample beats in, pixel beats out.
// Depends on vpm_pkg for the channel width.
interface vpm_req_if #(parameter int SAMPLE_WIDTH = 16);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface vpm_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [vpm_pkg::CHAN_WIDTH-1:0]  red;
   logic [vpm_pkg::CHAN_WIDTH-1:0]  green;
   logic [vpm_pkg::CHAN_WIDTH-1:0]  blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// File: sv/value_to_pseudocolor_map.sv
// Top level of the value to pseudocolour mapper: a thirteen-stage pipeline
// with a bit-per-stage divider. Depends on vpm_pkg and the channel interfaces.
//
// Usage: each beat on req_chan carries one signed sample; each beat on rsp_chan
// carries the red, green and blue intensities of its pixel, in order.
// The colour scale and mode are set through the csr_ port, a write taking
// effect at the clock edge where csr_wen is high. Write it only while no
// beat is in flight.
// Throughput: one beat per cycle while rsp_chan.ready is high, as every stage
// can take a new beat in each cycle. The eight divider stages, each resolving
// one quotient bit of the percentage and gray ratio, make up most of the latency.
// Stalls: every stage holds a valid bit and loads only when the stage after
// it can take its contents, so bubbles close up and req_chan.ready falls
// only once all thirteen stages are full and rsp_chan.ready is low.
// Reset: synchronous and active high; empties the pipeline and sets rainbow
// linear mode with the range from zero to the largest positive sample.
module value_to_pseudocolor_map #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   vpm_req_if.sink                              req_chan,
   vpm_rsp_if.source                            rsp_chan,
   input  logic                                 csr_wen,
   input  logic [vpm_pkg::REG_INDEX_WIDTH-1:0]  csr_index,
   input  logic [SAMPLE_WIDTH-1:0]              csr_wdata
);
   import vpm_pkg::*;

   localparam int W = SAMPLE_WIDTH;
   localparam int RW = W + QUOT_WIDTH;
   localparam int DIV_STEPS = QUOT_WIDTH;
   localparam int NS = DIV_STEPS + 5;
   localparam int STG_IN = 0;
   localparam int STG_SUB = 1;
   localparam int STG_MUL = 2;
   localparam int STG_DIV0 = 3;
   localparam int STG_PCT = STG_DIV0 + DIV_STEPS;
   localparam int STG_OUT = NS - 1;
   localparam logic signed [W-1:0] HIGH_RESET = {1'b0, {(W-1){1'b1}}};

   // Configuration and values derived from it.
   map_mode_type         mode_ff;
   logic signed [W-1:0]  low_ff;
   logic signed [W-1:0]  high_ff;
   logic signed [W:0]    span_full;
   logic [W-1:0]         span_in;
   logic [W-1:0]         span_ff;
   logic signed [W:0]    sum_in;
   logic signed [W:0]    sum_ff;
   logic                 range_ok_in;
   logic                 range_ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RAINBOW_LINEAR;
         low_ff  <= '0;
         high_ff <= HIGH_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            REG_MAP_MODE:   mode_ff <= map_mode_type'(csr_wdata[MODE_WIDTH-1:0]);
            REG_RANGE_LOW:  low_ff  <= signed'(csr_wdata);
            REG_RANGE_HIGH: high_ff <= signed'(csr_wdata);
            default: ;
         endcase
      end
   end

   always_comb begin
      span_full   = $signed({high_ff[W-1], high_ff}) - $signed({low_ff[W-1], low_ff});
      span_in     = span_full[W-1:0];
      sum_in      = $signed({high_ff[W-1], high_ff}) + $signed({low_ff[W-1], low_ff});
      range_ok_in = span_full > 0;
   end

   always_ff @(posedge clock) begin
      span_ff     <= span_in;
      sum_ff      <= sum_in;
      range_ok_ff <= range_ok_in;
   end

   // Stage handshake.
   logic [NS-1:0] valid_ff;
   logic [NS-1:0] valid_in;
   logic [NS-1:0] up_valid;
   logic [NS-1:0] stage_ready;

   always_comb begin
      stage_ready[NS-1] = !valid_ff[NS-1] || rsp_chan.ready;
      for (int i = NS - 2; i >= 0; i--) begin
         stage_ready[i] = !valid_ff[i] || stage_ready[i+1];
      end
      up_valid = {valid_ff[NS-2:0], req_chan.valid};
      valid_in = (stage_ready & up_valid) | (~stage_ready & valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_chan.ready = stage_ready[STG_IN];

   // Input register.
   logic signed [W-1:0] sample_ff;

   always_ff @(posedge clock) begin
      if (stage_ready[STG_IN]) begin
         sample_ff <= req_chan.sample;
      end
   end

   // Offset from the low bound and the midpoint test.
   logic signed [W:0] scaled_in;
   logic signed [W:0] scaled_ff;
   logic              bright_in;
   logic              bright_ff;

   always_comb begin
      scaled_in = $signed({sample_ff[W-1], sample_ff}) - $signed({low_ff[W-1], low_ff});
      bright_in = $signed({sample_ff[W-1], sample_ff, 1'b0}) < $signed({sum_ff[W], sum_ff});
   end

   always_ff @(posedge clock) begin
      if (stage_ready[STG_SUB]) begin
         scaled_ff <= scaled_in;
         bright_ff <= bright_in;
      end
   end

   // Clamp tests and the two dividends.
   flag_type        flags_mul_in;
   flag_type        flags_mul_ff;
   logic [RW-1:0]   num_p_in;
   logic [RW-1:0]   num_p_ff;
   logic [RW-1:0]   num_g_in;
   logic [RW-1:0]   num_g_ff;

   always_comb begin
      flags_mul_in.below  = scaled_ff[W] || (scaled_ff == '0);
      flags_mul_in.above  = scaled_ff >= $signed({1'b0, span_ff});
      flags_mul_in.bright = bright_ff;
      num_p_in = RW'(scaled_ff[W-1:0]) * RW'(PCT_FULL);
      num_g_in = {scaled_ff[W-1:0], {QUOT_WIDTH{1'b0}}} - RW'(scaled_ff[W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (stage_ready[STG_MUL]) begin
         flags_mul_ff <= flags_mul_in;
         num_p_ff     <= num_p_in;
         num_g_ff     <= num_g_in;
      end
   end

   // Restoring divider, one quotient bit per stage on both lanes.
   logic [RW-1:0]          rem_p_ff [DIV_STEPS];
   logic [RW-1:0]          rem_g_ff [DIV_STEPS];
   logic [QUOT_WIDTH-1:0]  quo_p_ff [DIV_STEPS];
   logic [QUOT_WIDTH-1:0]  quo_g_ff [DIV_STEPS];
   flag_type               flags_div_ff [DIV_STEPS];

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      localparam int SH = DIV_STEPS - 1 - j;
      logic [RW-1:0]          rem_p_src;
      logic [RW-1:0]          rem_g_src;
      logic [QUOT_WIDTH-1:0]  quo_p_src;
      logic [QUOT_WIDTH-1:0]  quo_g_src;
      flag_type               flags_src;
      logic [RW-1:0]          divisor;
      logic                   take_p;
      logic                   take_g;
      logic [RW-1:0]          rem_p_in;
      logic [RW-1:0]          rem_g_in;
      logic [QUOT_WIDTH-1:0]  quo_p_in;
      logic [QUOT_WIDTH-1:0]  quo_g_in;

      if (j == 0) begin : g_head
         assign rem_p_src = num_p_ff;
         assign rem_g_src = num_g_ff;
         assign quo_p_src = '0;
         assign quo_g_src = '0;
         assign flags_src = flags_mul_ff;
      end else begin : g_body
         assign rem_p_src = rem_p_ff[j-1];
         assign rem_g_src = rem_g_ff[j-1];
         assign quo_p_src = quo_p_ff[j-1];
         assign quo_g_src = quo_g_ff[j-1];
         assign flags_src = flags_div_ff[j-1];
      end

      always_comb begin
         divisor  = RW'(span_ff) << SH;
         take_p   = rem_p_src >= divisor;
         take_g   = rem_g_src >= divisor;
         rem_p_in = take_p ? rem_p_src - divisor : rem_p_src;
         rem_g_in = take_g ? rem_g_src - divisor : rem_g_src;
         quo_p_in = {quo_p_src[QUOT_WIDTH-2:0], take_p};
         quo_g_in = {quo_g_src[QUOT_WIDTH-2:0], take_g};
      end

      always_ff @(posedge clock) begin
         if (stage_ready[STG_DIV0+j]) begin
            rem_p_ff[j]     <= rem_p_in;
            rem_g_ff[j]     <= rem_g_in;
            quo_p_ff[j]     <= quo_p_in;
            quo_g_ff[j]     <= quo_g_in;
            flags_div_ff[j] <= flags_src;
         end
      end
   end

   // Percentage and linear gray level after clamping.
   logic [PCT_WIDTH-1:0]   pct_in;
   logic [PCT_WIDTH-1:0]   pct_ff;
   logic [CHAN_WIDTH-1:0]  gray_in;
   logic [CHAN_WIDTH-1:0]  gray_ff;
   logic                   bright_pct_ff;
   flag_type               flags_last;

   always_comb begin
      flags_last = flags_div_ff[DIV_STEPS-1];
      if (flags_last.below) begin
         pct_in  = '0;
         gray_in = CHAN_WIDTH'(GRAY_FULL);
      end else if (flags_last.above) begin
         pct_in  = PCT_WIDTH'(PCT_FULL);
         gray_in = '0;
      end else begin
         pct_in  = quo_p_ff[DIV_STEPS-1][PCT_WIDTH-1:0];
         gray_in = CHAN_WIDTH'(GRAY_FULL) - quo_g_ff[DIV_STEPS-1]
                   - CHAN_WIDTH'(rem_g_ff[DIV_STEPS-1] != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[STG_PCT]) begin
         pct_ff        <= pct_in;
         gray_ff       <= gray_in;
         bright_pct_ff <= flags_last.bright;
      end
   end

   // Colour selection and output register.
   rgb_type               pixel_in;
   rgb_type               pixel_ff;
   logic [BAND_WIDTH-1:0] band;

   always_comb begin
      band = band_of(pct_ff);
      if (mode_ff == MODE_BLACK_WHITE) begin
         pixel_in = bright_pct_ff ? RGB_WHITE : RGB_BLACK;
      end else if (!range_ok_ff) begin
         pixel_in = RGB_BLACK;
      end else begin
         case (mode_ff)
            MODE_RAINBOW_LINEAR: pixel_in = rainbow_linear(pct_ff);
            MODE_RAINBOW_STEP:   pixel_in = rainbow_step(band);
            MODE_GRAY_LINEAR:    pixel_in = '{red: gray_ff, green: gray_ff, blue: gray_ff};
            MODE_GRAY_STEP: begin
               pixel_in = '{red: gray_step(band), green: gray_step(band),
                            blue: gray_step(band)};
            end
            default:             pixel_in = RGB_BLACK;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[STG_OUT]) begin
         pixel_ff <= pixel_in;
      end
   end

   assign rsp_chan.valid = valid_ff[STG_OUT];
   assign rsp_chan.red   = pixel_ff.red;
   assign rsp_chan.green = pixel_ff.green;
   assign rsp_chan.blue  = pixel_ff.blue;

   // The input side only stalls when the whole pipeline is full and the output is held.
   a_stall_from_output: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (rsp_chan.valid && !rsp_chan.ready && (&valid_ff)))
      else $error("input stalled while the pipeline had room");

   a_gray_is_neutral: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (mode_ff == MODE_GRAY_LINEAR || mode_ff == MODE_GRAY_STEP))
      |-> (rsp_chan.red == rsp_chan.green && rsp_chan.green == rsp_chan.blue))
      else $error("gray pixel with unequal channels");

   a_black_white_levels: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && mode_ff == MODE_BLACK_WHITE)
      |-> (pixel_ff == RGB_WHITE || pixel_ff == RGB_BLACK))
      else $error("black-white pixel neither black nor white");

   a_bad_range_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !range_ok_ff && mode_ff != MODE_BLACK_WHITE)
      |-> (pixel_ff == RGB_BLACK))
      else $error("pixel not black for an empty range");

endmodule

// File: tb/tb_value_to_pseudocolor_map.sv
// Self-checking testbench for value_to_pseudocolor_map: drives sample beats under
// varied colour scales and handshake pressure, and checks every pixel beat.
// Depends on vpm_pkg, the channel interfaces and the value_to_pseudocolor_map RTL.
module tb_value_to_pseudocolor_map;
   import vpm_pkg::*;

   localparam int SAMPLE_W = 16;
   localparam int RANDOM_ITEMS = 1600;
   localparam int HOLD_CYCLES = 80;
   localparam int DRAIN_CYCLES = 24;
   localparam int CYCLE_LIMIT = 400000;
   localparam longint SAMPLE_MIN = -32768;
   localparam longint SAMPLE_MAX = 32767;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_SPARE = 2'd3;
   localparam logic [MODE_WIDTH-1:0] MODE_SPARE = 3'd7;
   localparam int SEND_IDLE [4] = '{0, 79, 0, 33};
   localparam int RECV_STALL [4] = '{0, 0, 79, 33};
   localparam logic [23:0] STEP_COLOURS [10] = '{
      24'hFF00FF, 24'h7F00FF, 24'h0000FF, 24'h007FFF, 24'h00FFFF,
      24'h00FF7F, 24'h00FF00, 24'hFFFF00, 24'hFF7F00, 24'hFF0000
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wen;
   logic [REG_INDEX_WIDTH-1:0] csr_index;
   logic [SAMPLE_W-1:0] csr_wdata;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int holds_asked = 0;
   int holds_served = 0;
   int samples_sent = 0;
   int scale_count = 0;
   int cycles = 0;

   vpm_req_if #(.SAMPLE_WIDTH(SAMPLE_W)) req_chan ();
   vpm_rsp_if rsp_chan ();

   value_to_pseudocolor_map #(.SAMPLE_WIDTH(SAMPLE_W)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   class pixel_ledger;
      logic [MODE_WIDTH-1:0] mode;
      logic signed [SAMPLE_W-1:0] low;
      logic signed [SAMPLE_W-1:0] high;
      rgb_type pending[$];
      int mismatches;
      int checked;

      function new();
         mode = MODE_RAINBOW_LINEAR;
         low = '0;
         high = 16'sd32767;
         mismatches = 0;
         checked = 0;
      endfunction

      function void apply_write(logic [REG_INDEX_WIDTH-1:0] idx, logic [SAMPLE_W-1:0] data);
         case (idx)
            REG_MAP_MODE: mode = data[MODE_WIDTH-1:0];
            REG_RANGE_LOW: low = data;
            REG_RANGE_HIGH: high = data;
            default: ;
         endcase
      endfunction

      function rgb_type shade(longint r, longint g, longint b);
         rgb_type c;
         c.red = r[7:0];
         c.green = g[7:0];
         c.blue = b[7:0];
         return c;
      endfunction

      function rgb_type rainbow_ramp(longint p);
         longint n;
         n = p - 5;
         if (n < 10) return shade((n < 0) ? 255 : 255 - n * 127 / 10, 0, 255);
         if (n < 20) return shade(127 - (n - 10) * 127 / 10, 0, 255);
         if (n < 30) return shade(0, (n - 20) * 127 / 10, 255);
         if (n < 40) return shade(0, 127 + (n - 30) * 127 / 10, 255);
         if (n < 50) return shade(0, 255, 255 - (n - 40) * 127 / 10);
         if (n < 60) return shade(0, 255, 127 - (n - 50) * 127 / 10);
         if (n < 70) return shade((n - 60) * 255 / 10, 255, 0);
         if (n < 80) return shade(255, 255 - ((n - 70) * 255 / 10) / 2, 0);
         if (n < 90) return shade(255, 127 - (n - 80) * 127 / 10, 0);
         return shade(255, 0, 0);
      endfunction

      function rgb_type colour_for(logic signed [SAMPLE_W-1:0] sample);
         longint s, lo, hi, span, scaled, p, band, g;
         s = sample;
         lo = low;
         hi = high;
         span = hi - lo;
         scaled = s - lo;
         if (mode == MODE_BLACK_WHITE) return (2 * s < lo + hi) ? RGB_WHITE : RGB_BLACK;
         if (mode > MODE_BLACK_WHITE || span <= 0) return RGB_BLACK;
         if (scaled <= 0) p = 0;
         else if (scaled >= span) p = 100;
         else p = scaled * 100 / span;
         band = (p / 10 > 9) ? 9 : p / 10;
         case (mode)
            MODE_RAINBOW_LINEAR: return rainbow_ramp(p);
            MODE_RAINBOW_STEP: return rgb_type'(STEP_COLOURS[band]);
            MODE_GRAY_LINEAR: begin
               if (scaled <= 0) g = 255;
               else if (scaled >= span) g = 0;
               else g = 255 - (scaled * 255 + span - 1) / span;
            end
            default: g = 255 - band * 255 / 9;
         endcase
         return shade(g, g, g);
      endfunction

      function void note_sample(logic signed [SAMPLE_W-1:0] sample);
         pending.push_back(colour_for(sample));
      endfunction

      function void check_pixel(logic [CHAN_WIDTH-1:0] red, green, blue);
         rgb_type want;
         if (pending.size() == 0) begin
            $error("pixel %0d/%0d/%0d arrived with no sample outstanding", red, green, blue);
            mismatches++;
            return;
         end
         want = pending.pop_front();
         checked++;
         if (red !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, red);
            mismatches++;
         end
         if (green !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, green);
            mismatches++;
         end
         if (blue !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, blue);
            mismatches++;
         end
      endfunction
   endclass

   pixel_ledger ledger;

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.sample <= s;
      do @(posedge clock); while (!req_chan.ready);
      ledger.note_sample(s);
      samples_sent++;
   endtask

   task automatic write_reg(input logic [REG_INDEX_WIDTH-1:0] idx,
                            input logic [SAMPLE_W-1:0] data);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      ledger.apply_write(idx, data);
   endtask

   // The pipeline must be empty before the scale changes, so every beat in
   // flight is drained first.
   task automatic set_scale(input logic [MODE_WIDTH-1:0] mode,
                            input logic [SAMPLE_W-MODE_WIDTH-1:0] pad,
                            input longint lo, input longint hi, input bit spare);
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (ledger.pending.size() != 0);
      write_reg(REG_MAP_MODE, {pad, mode});
      write_reg(REG_RANGE_LOW, SAMPLE_W'(lo));
      write_reg(REG_RANGE_HIGH, SAMPLE_W'(hi));
      if (spare) write_reg(REG_SPARE, SAMPLE_W'($urandom));
      csr_wen <= 1'b0;
      scale_count++;
   endtask

   function automatic longint rand_level();
      return longint'($signed(SAMPLE_W'($urandom)));
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] draw_sample();
      longint lo, hi, margin, a, b;
      int unsigned pick;
      lo = ledger.low;
      hi = ledger.high;
      if (lo > hi) begin
         a = lo;
         lo = hi;
         hi = a;
      end
      margin = (hi - lo) / 8 + 2;
      pick = $urandom_range(9);
      if (pick == 0) return SAMPLE_W'($urandom);
      if (pick == 1) return ledger.low;
      if (pick == 2) return ledger.high;
      if (pick == 3) begin
         a = (lo + hi) / 2 - 1;
         b = a + 2;
      end else begin
         a = lo - margin;
         b = hi + margin;
      end
      if (a < SAMPLE_MIN) a = SAMPLE_MIN;
      if (b > SAMPLE_MAX) b = SAMPLE_MAX;
      return SAMPLE_W'(a + longint'($urandom_range(32'(b - a))));
   endfunction

   task automatic pick_scale();
      longint lo, hi;
      int unsigned r;
      logic [MODE_WIDTH-1:0] mode;
      r = $urandom_range(19);
      mode = (r < 17) ? MODE_WIDTH'(r % 5) : MODE_WIDTH'(r - 12);
      case ($urandom_range(9))
         0: begin
            lo = SAMPLE_MIN;
            hi = SAMPLE_MAX;
         end
         1: begin
            lo = SAMPLE_MAX;
            hi = SAMPLE_MIN;
         end
         2: begin
            lo = rand_level();
            hi = lo;
         end
         3, 4: begin
            lo = rand_level();
            hi = lo + $urandom_range(200, 1);
         end
         5: begin
            lo = rand_level();
            hi = lo + $urandom_range(10, 1);
         end
         6: begin
            lo = 0;
            hi = SAMPLE_MAX;
         end
         default: begin
            lo = rand_level();
            hi = rand_level();
         end
      endcase
      if (hi > SAMPLE_MAX) hi = SAMPLE_MAX;
      set_scale(mode, $urandom_range(1) ? (SAMPLE_W-MODE_WIDTH)'($urandom) : '0,
                lo, hi, $urandom_range(3) == 0);
   endtask

   initial begin : pixel_sink
      int hold_left;
      hold_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready)
            ledger.check_pixel(rsp_chan.red, rsp_chan.green, rsp_chan.blue);
         if (holds_served != holds_asked) begin
            holds_served = holds_asked;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("value_to_pseudocolor_map test failed");
         $finish;
      end
   end

   initial begin : stimulus
      int seg, seg_len, done_random, phase;
      ledger = new();
      req_chan.valid <= 1'b0;
      req_chan.sample <= '0;
      csr_wen <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset scale first, then each mode at its edges and turning points.
      send_sample(-32768);
      send_sample(0);
      send_sample(1638);
      send_sample(32767);
      set_scale(MODE_RAINBOW_LINEAR, '0, 0, 100, 0);
      send_sample(3);
      send_sample(14);
      send_sample(64);
      send_sample(77);
      send_sample(100);
      set_scale(MODE_GRAY_LINEAR, '0, SAMPLE_MIN, SAMPLE_MAX, 0);
      send_sample(-32768);
      send_sample(1);
      send_sample(32767);
      set_scale(MODE_GRAY_STEP, '0, -100, 100, 0);
      send_sample(-1);
      send_sample(80);
      set_scale(MODE_RAINBOW_STEP, '0, 50, 50, 1);
      send_sample(50);
      set_scale(MODE_BLACK_WHITE, '0, 10, 20, 0);
      send_sample(14);
      send_sample(15);
      send_sample(16);
      // Black-white still thresholds when the range is reversed.
      set_scale(MODE_BLACK_WHITE, '0, 20, 10, 0);
      send_sample(14);
      send_sample(15);
      set_scale(MODE_SPARE, '0, 0, 100, 0);
      send_sample(5);

      seg = 0;
      done_random = 0;
      while (done_random < RANDOM_ITEMS) begin
         pick_scale();
         phase = seg % 4;
         send_idle_pct = SEND_IDLE[phase];
         stall_pct = RECV_STALL[phase];
         seg_len = $urandom_range(60, 20);
         if (seg % 8 == 0) begin
            seg_len = 60;
            holds_asked++;
         end
         repeat (seg_len) send_sample(draw_sample());
         done_random += seg_len;
         seg++;
      end

      req_chan.valid <= 1'b0;
      do @(posedge clock); while (ledger.pending.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (ledger.pending.size() != 0) begin
         $error("%0d pixels never arrived", ledger.pending.size());
         ledger.mismatches++;
      end
      $display("Sent %0d sample beats across %0d colour scales, unused mode codes included,",
               samples_sent, scale_count);
      $display("with %0d long output hold-offs; %0d pixel beats checked, %0d mismatches.",
               holds_asked, ledger.checked, ledger.mismatches);
      if (ledger.mismatches == 0) begin
         $display("value_to_pseudocolor_map test passed");
      end else begin
         $display("value_to_pseudocolor_map test failed");
      end
      $finish;
   end
endmodule
